@@ rtl/core/lnr_pkg.sv @@
package lnr_pkg;

	localparam int COORD_W = 10;
	localparam int CFG_W   = 11;

	// transaction opcodes
	localparam logic OP_STORE = 1'b0;
	localparam logic OP_READ  = 1'b1;

	// configuration register indexes
	localparam logic [1:0] REG_SRC_W = 2'd0;
	localparam logic [1:0] REG_SRC_H = 2'd1;
	localparam logic [1:0] REG_DST_W = 2'd2;
	localparam logic [1:0] REG_DST_H = 2'd3;

	localparam logic [9:0]  RST_SRC_W = 10'd512;
	localparam logic [9:0]  RST_SRC_H = 10'd512;
	localparam logic [10:0] RST_DST_W = 11'd640;
	localparam logic [10:0] RST_DST_H = 11'd640;

	// pad byte, level is byte times 257
	localparam logic [7:0]  PAD_BYTE  = 8'd114;
	localparam logic [15:0] PAD_LEVEL = {PAD_BYTE, PAD_BYTE};

	typedef struct packed {
		logic               opcode;
		logic [COORD_W-1:0] x_coord;
		logic [COORD_W-1:0] y_coord;
		logic [7:0]         blue_in;
		logic [7:0]         green_in;
		logic [7:0]         red_in;
	} in_item_t;

	typedef struct packed {
		logic [15:0] red_level;
		logic [15:0] green_level;
		logic [15:0] blue_level;
		logic        is_padding;
	} out_item_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_GEO_SEL,
		ST_GEO_W,
		ST_GEO_H,
		ST_CHK,
		ST_DIV_X,
		ST_DIV_Y,
		ST_RD_MEM,
		ST_RD_DATA,
		ST_RESULT
	} state_t;

endpackage

@@ rtl/core/lnr_ram.sv @@
module lnr_ram #(
	parameter int WIDTH = 24,
	parameter int DEPTH = 262144,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

@@ rtl/core/letterbox_nearest_resize_top.sv @@
// channel  | direction | handshake            | payload
// ---------+-----------+----------------------+---------------------------------
// in       | input     | in_valid / in_ready  | in_item  (store or read request)
// out      | output    | out_valid / out_ready| out_item (levels and pad flag)
// cfg      | input     | cfg_we               | cfg_index, cfg_wdata
//
// store: written when accepted; read in the image: two divisions on one shared restoring divider
// and a memory read; pad read: the check state goes straight to the result state
// after reset and every config write in_ready stays low while the divider recomputes the
// letterbox geometry; a finished result waits in the output register, the next transaction is
// taken and stalls only if that register is still full
module letterbox_nearest_resize_top
	import lnr_pkg::*;
#(
	parameter int MAX_SRC_WIDTH  = 512,
	parameter int MAX_SRC_HEIGHT = 512,
	parameter int MAX_DST_SIDE   = 1024
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  in_item_t         in_item,
	output logic             out_valid,
	input  logic             out_ready,
	output out_item_t        out_item,
	input  logic             cfg_we,
	input  logic [1:0]       cfg_index,
	input  logic [CFG_W-1:0] cfg_wdata
);

	localparam int SW_BITS = $clog2(MAX_SRC_WIDTH + 1);
	localparam int SH_BITS = $clog2(MAX_SRC_HEIGHT + 1);
	localparam int DS_BITS = $clog2(MAX_DST_SIDE + 1);
	localparam int SZ_A    = (SW_BITS > SH_BITS) ? SW_BITS : SH_BITS;
	localparam int SZ_B    = (SZ_A > DS_BITS) ? SZ_A : DS_BITS;
	localparam int SZ_W    = (SZ_B > CFG_W) ? SZ_B : CFG_W;
	localparam int DIV_W   = 2 * SZ_W;
	localparam int CNT_W   = $clog2(DIV_W + 2);
	localparam int DEPTH   = MAX_SRC_WIDTH * MAX_SRC_HEIGHT;
	localparam int AW      = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	localparam logic [SZ_W-1:0]  MAX_SW_C  = SZ_W'(MAX_SRC_WIDTH);
	localparam logic [SZ_W-1:0]  MAX_SH_C  = SZ_W'(MAX_SRC_HEIGHT);
	localparam logic [SZ_W-1:0]  MAX_DS_C  = SZ_W'(MAX_DST_SIDE);
	localparam logic [SZ_W-1:0]  ONE_C     = SZ_W'(1);
	localparam logic [CNT_W-1:0] CNT_DONE  = CNT_W'(DIV_W + 1);

	state_t state_q, state_d;

	logic [9:0]  src_w_q, src_h_q;
	logic [10:0] dst_w_q, dst_h_q;
	logic        stale_q;
	logic        out_valid_q;
	out_item_t   out_item_q;
	out_item_t   res_q;

	logic [SZ_W-1:0] sw, sh, tw, th, sw_m1, sh_m1;
	logic [SZ_W-1:0] x_q, y_q;
	logic [SZ_W-1:0] num_q, den_q;
	logic [SZ_W-1:0] new_w_q, new_h_q, pad_x_q, pad_y_q;
	logic [SZ_W-1:0] sx_q, sy_q;
	logic [SZ_W-1:0] quot_w, sx_c, sy_c;
	logic [DIV_W-1:0] prod_a, prod_b;
	logic             cross_le;
	logic             in_image;

	// shared restoring divider
	logic [CNT_W-1:0] cnt_q;
	logic [DIV_W-1:0] div_dvd_q, div_dvd_in, div_dvd_next;
	logic [SZ_W-1:0]  div_dvs_q, div_dvs_in;
	logic [SZ_W-1:0]  div_rem_q;
	logic [SZ_W:0]    rem_sh, rem_sub;
	logic             rem_ge;
	logic             div_done;
	logic             div_state;

	logic             load_out;
	logic             in_acc;
	logic             st_we;
	logic [AW-1:0]    st_addr, rd_addr;
	logic             rd_en;
	logic [23:0]      ram_rdata;

	// saturate sizes into their legal range
	function automatic logic [SZ_W-1:0] sat_size(input logic [SZ_W-1:0] v,
	                                             input logic [SZ_W-1:0] hi);
		logic [SZ_W-1:0] r;
		if (v == '0) begin
			r = ONE_C;
		end else if (v > hi) begin
			r = hi;
		end else begin
			r = v;
		end
		return r;
	endfunction

	always_comb begin
		sw    = sat_size(SZ_W'(src_w_q), MAX_SW_C);
		sh    = sat_size(SZ_W'(src_h_q), MAX_SH_C);
		tw    = sat_size(SZ_W'(dst_w_q), MAX_DS_C);
		th    = sat_size(SZ_W'(dst_h_q), MAX_DS_C);
		sw_m1 = sw - ONE_C;
		sh_m1 = sh - ONE_C;
	end

	assign prod_a   = DIV_W'(tw) * DIV_W'(sh);
	assign prod_b   = DIV_W'(th) * DIV_W'(sw);
	assign cross_le = (prod_a <= prod_b);

	assign in_image = (x_q < tw) && (y_q < th) &&
	                  (x_q >= pad_x_q) && (x_q < pad_x_q + new_w_q) &&
	                  (y_q >= pad_y_q) && (y_q < pad_y_q + new_h_q);

	// divider step
	assign rem_sh       = {div_rem_q, div_dvd_q[DIV_W-1]};
	assign rem_ge       = (rem_sh >= {1'b0, div_dvs_q});
	assign rem_sub      = rem_ge ? (rem_sh - {1'b0, div_dvs_q}) : rem_sh;
	assign div_dvd_next = {div_dvd_q[DIV_W-2:0], rem_ge};
	assign div_done     = (cnt_q == CNT_DONE);
	assign quot_w       = SZ_W'(div_dvd_q);

	// nearest source index, clamped to the source size
	assign sx_c = (div_dvd_q > DIV_W'(sw_m1)) ? sw_m1 : quot_w;
	assign sy_c = (div_dvd_q > DIV_W'(sh_m1)) ? sh_m1 : quot_w;

	always_comb begin
		div_dvd_in = '0;
		div_dvs_in = den_q;
		case (state_q)
			ST_GEO_W: begin
				div_dvd_in = DIV_W'(sw) * DIV_W'(num_q);
				div_dvs_in = den_q;
			end
			ST_GEO_H: begin
				div_dvd_in = DIV_W'(sh) * DIV_W'(num_q);
				div_dvs_in = den_q;
			end
			ST_DIV_X: begin
				div_dvd_in = DIV_W'(x_q - pad_x_q) * DIV_W'(den_q);
				div_dvs_in = num_q;
			end
			ST_DIV_Y: begin
				div_dvd_in = DIV_W'(y_q - pad_y_q) * DIV_W'(den_q);
				div_dvs_in = num_q;
			end
			default: begin
				div_dvd_in = '0;
				div_dvs_in = den_q;
			end
		endcase
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (stale_q) begin
					state_d = ST_GEO_SEL;
				end else if (in_valid && in_item.opcode == OP_READ) begin
					state_d = ST_CHK;
				end
			end
			ST_GEO_SEL: state_d = ST_GEO_W;
			ST_GEO_W: begin
				if (div_done) state_d = ST_GEO_H;
			end
			ST_GEO_H: begin
				if (div_done) state_d = ST_IDLE;
			end
			ST_CHK: begin
				state_d = in_image ? ST_DIV_X : ST_RESULT;
			end
			ST_DIV_X: begin
				if (div_done) state_d = ST_DIV_Y;
			end
			ST_DIV_Y: begin
				if (div_done) state_d = ST_RD_MEM;
			end
			ST_RD_MEM:  state_d = ST_RD_DATA;
			ST_RD_DATA: state_d = ST_RESULT;
			ST_RESULT: begin
				if (!out_valid_q || out_ready) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
		// a config write during the geometry pass starts it over
		if (cfg_we && (state_q inside {ST_GEO_SEL, ST_GEO_W, ST_GEO_H})) begin
			state_d = ST_GEO_SEL;
		end
	end

	// state outputs
	always_comb begin
		in_ready  = (state_q == ST_IDLE) && !stale_q;
		load_out  = (state_q == ST_RESULT) && (!out_valid_q || out_ready);
		div_state = state_q inside {ST_GEO_W, ST_GEO_H, ST_DIV_X, ST_DIV_Y};
		rd_en     = (state_q == ST_RD_MEM);
	end

	assign in_acc  = in_valid && in_ready;
	assign st_we   = in_acc && (in_item.opcode == OP_STORE) &&
	                 (32'(in_item.x_coord) < 32'(MAX_SRC_WIDTH)) &&
	                 (32'(in_item.y_coord) < 32'(MAX_SRC_HEIGHT));
	assign st_addr = AW'(32'(in_item.y_coord) * 32'(MAX_SRC_WIDTH) + 32'(in_item.x_coord));
	assign rd_addr = AW'(32'(sy_q) * 32'(MAX_SRC_WIDTH) + 32'(sx_q));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			stale_q     <= 1'b1;
			out_valid_q <= 1'b0;
			cnt_q       <= '0;
			src_w_q     <= RST_SRC_W;
			src_h_q     <= RST_SRC_H;
			dst_w_q     <= RST_DST_W;
			dst_h_q     <= RST_DST_H;
		end else begin
			state_q <= state_d;

			if (state_d != state_q) begin
				cnt_q <= '0;
			end else if (div_state && !div_done) begin
				cnt_q <= cnt_q + CNT_W'(1);
			end

			if (cfg_we) begin
				stale_q <= 1'b1;
			end else if (state_q == ST_GEO_H && div_done) begin
				stale_q <= 1'b0;
			end

			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end

			if (cfg_we) begin
				case (cfg_index)
					REG_SRC_W: src_w_q <= cfg_wdata[9:0];
					REG_SRC_H: src_h_q <= cfg_wdata[9:0];
					REG_DST_W: dst_w_q <= cfg_wdata;
					REG_DST_H: dst_h_q <= cfg_wdata;
					default: ;
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			x_q <= SZ_W'(in_item.x_coord);
			y_q <= SZ_W'(in_item.y_coord);
		end

		// first cycle of a division loads operands, then one quotient bit a cycle
		if (div_state) begin
			if (cnt_q == '0) begin
				div_dvd_q <= div_dvd_in;
				div_dvs_q <= div_dvs_in;
				div_rem_q <= '0;
			end else if (!div_done) begin
				div_dvd_q <= div_dvd_next;
				div_rem_q <= SZ_W'(rem_sub);
			end
		end

		case (state_q)
			ST_GEO_SEL: begin
				num_q <= cross_le ? tw : th;
				den_q <= cross_le ? sw : sh;
			end
			ST_GEO_W: begin
				if (div_done) new_w_q <= quot_w;
			end
			ST_GEO_H: begin
				if (div_done) begin
					new_h_q <= quot_w;
					pad_x_q <= (tw - new_w_q) >> 1;
					pad_y_q <= (th - quot_w) >> 1;
				end
			end
			ST_CHK: begin
				res_q.red_level   <= PAD_LEVEL;
				res_q.green_level <= PAD_LEVEL;
				res_q.blue_level  <= PAD_LEVEL;
				res_q.is_padding  <= 1'b1;
			end
			ST_DIV_X: begin
				if (div_done) sx_q <= sx_c;
			end
			ST_DIV_Y: begin
				if (div_done) sy_q <= sy_c;
			end
			ST_RD_DATA: begin
				res_q.red_level   <= {ram_rdata[23:16], ram_rdata[23:16]};
				res_q.green_level <= {ram_rdata[15:8], ram_rdata[15:8]};
				res_q.blue_level  <= {ram_rdata[7:0], ram_rdata[7:0]};
				res_q.is_padding  <= 1'b0;
			end
			default: ;
		endcase

		if (load_out) begin
			out_item_q <= res_q;
		end
	end

	lnr_ram #(
		.WIDTH (24),
		.DEPTH (DEPTH),
		.AW    (AW)
	) u_store (
		.clk   (clk),
		.we    (st_we),
		.waddr (st_addr),
		.wdata ({in_item.red_in, in_item.green_in, in_item.blue_in}),
		.re    (rd_en),
		.raddr (rd_addr),
		.rdata (ram_rdata)
	);

	assign out_valid = out_valid_q;
	assign out_item  = out_item_q;

endmodule

@@ bench/letterbox_nearest_resize_top_test.sv @@
module letterbox_nearest_resize_top_test;
	timeunit 1ns;
	timeprecision 1ps;

	import lnr_pkg::*;

	localparam int CLK_PERIOD      = 10;
	localparam int RESET_CYCLES    = 9;
	localparam int SRC_W_MAX       = 512;
	localparam int SRC_H_MAX       = 512;
	localparam int DST_MAX         = 1024;
	// the slowest request is a read in the image, a pad read or a store is quicker
	localparam int SETTLE_CYCLES   = 60;
	localparam int DRAIN_LIMIT     = 100000;
	localparam int ITEMS_PER_PHASE = 135;
	localparam int NUM_FIXED       = 8;
	localparam int NUM_PHASES      = 14;

	// source width, source height, target width, target height as written
	localparam logic [10:0] GEO_SET [NUM_FIXED][4] = '{
		'{11'd1,    11'd1,   11'd1,    11'd1},
		'{11'd0,    11'd512, 11'd1024, 11'd1024},
		'{11'd1023, 11'd7,   11'd2047, 11'd0},
		'{11'h400,  11'd3,   11'd5,    11'd1024},
		'{11'd512,  11'd512, 11'd1024, 11'd1024},
		'{11'd13,   11'd9,   11'd40,   11'd33},
		'{11'd9,    11'd13,  11'd33,   11'd40},
		'{11'd512,  11'd1,   11'd1024, 11'd2}
	};

	logic             clk       = 1'b0;
	logic             arst_n    = 1'b0;
	logic             in_valid  = 1'b0;
	logic             in_ready;
	in_item_t         in_item   = '0;
	logic             out_valid;
	logic             out_ready = 1'b0;
	out_item_t        out_item;
	logic             cfg_we    = 1'b0;
	logic [1:0]       cfg_index = REG_SRC_W;
	logic [CFG_W-1:0] cfg_wdata = '0;

	// geometry registers as the block holds them
	logic [9:0]  src_w_cfg = RST_SRC_W;
	logic [9:0]  src_h_cfg = RST_SRC_H;
	logic [10:0] dst_w_cfg = RST_DST_W;
	logic [10:0] dst_h_cfg = RST_DST_H;

	bit [23:0]   src_pixels [SRC_W_MAX*SRC_H_MAX];
	// pixels that some queued store already covers
	bit          pixel_loaded [SRC_W_MAX*SRC_H_MAX];
	out_item_t   levels_due [$];
	in_item_t    stim_queue [$];

	bit          in_taken       = 1'b0;
	bit          bursts_on      = 1'b1;
	int unsigned in_gap         = 0;
	int unsigned out_stall      = 0;
	int unsigned mismatch_count = 0;

	letterbox_nearest_resize_top u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_item   (in_item),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_item  (out_item),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata)
	);

	always #(CLK_PERIOD/2) clk = ~clk;

	function automatic int unsigned fit_size(int unsigned v, int unsigned hi);
		if (v == 0)
			return 1;
		if (v > hi)
			return hi;
		return v;
	endfunction

	// maps a destination pixel back to the source, 0 when it is pad
	function automatic bit locate_source(input logic [9:0] dx, input logic [9:0] dy,
			output int unsigned src_idx);
		int unsigned sw, sh, tw, th, num, den, new_w, new_h, pad_x, pad_y, sx, sy;
		sw = fit_size(32'(src_w_cfg), SRC_W_MAX);
		sh = fit_size(32'(src_h_cfg), SRC_H_MAX);
		tw = fit_size(32'(dst_w_cfg), DST_MAX);
		th = fit_size(32'(dst_h_cfg), DST_MAX);
		src_idx = 0;
		if (tw * sh <= th * sw) begin
			num = tw;
			den = sw;
		end else begin
			num = th;
			den = sh;
		end
		new_w = sw * num / den;
		new_h = sh * num / den;
		pad_x = (tw - new_w) / 2;
		pad_y = (th - new_h) / 2;
		if (dx < tw && dy < th && dx >= pad_x && dx < pad_x + new_w &&
				dy >= pad_y && dy < pad_y + new_h) begin
			sx = (dx - pad_x) * den / num;
			sy = (dy - pad_y) * den / num;
			if (sx > sw - 1)
				sx = sw - 1;
			if (sy > sh - 1)
				sy = sh - 1;
			src_idx = sy * SRC_W_MAX + sx;
			return 1'b1;
		end
		return 1'b0;
	endfunction

	function automatic out_item_t resize_levels(logic [9:0] dx, logic [9:0] dy);
		out_item_t   res;
		int unsigned idx;
		bit [23:0]   px;
		res = '{PAD_LEVEL, PAD_LEVEL, PAD_LEVEL, 1'b1};
		if (locate_source(dx, dy, idx)) begin
			px = src_pixels[idx];
			res.red_level   = {2{px[23:16]}};
			res.green_level = {2{px[15:8]}};
			res.blue_level  = {2{px[7:0]}};
			res.is_padding  = 1'b0;
		end
		return res;
	endfunction

	task automatic report_mismatch(string what);
		$display("mismatch at %0t ns: %s", $realtime, what);
		mismatch_count++;
	endtask

	task automatic queue_store(logic [9:0] x, logic [9:0] y, logic [7:0] b, logic [7:0] g,
			logic [7:0] r);
		in_item_t it;
		it = '{OP_STORE, x, y, b, g, r};
		stim_queue.push_back(it);
		if (x < SRC_W_MAX && y < SRC_H_MAX)
			pixel_loaded[y * SRC_W_MAX + x] = 1'b1;
	endtask

	// a read that lands in the image gets its source pixel stored first if needed
	task automatic queue_read(logic [9:0] x, logic [9:0] y);
		in_item_t    it;
		int unsigned idx;
		if (locate_source(x, y, idx) && !pixel_loaded[idx])
			queue_store(10'(idx % SRC_W_MAX), 10'(idx / SRC_W_MAX), 8'($urandom),
				8'($urandom), 8'($urandom));
		it = '{OP_READ, x, y, 8'($urandom), 8'($urandom), 8'($urandom)};
		stim_queue.push_back(it);
	endtask

	task automatic queue_traffic(int n);
		int unsigned sw, sh, x_hi, y_hi;
		sw   = fit_size(32'(src_w_cfg), SRC_W_MAX);
		sh   = fit_size(32'(src_h_cfg), SRC_H_MAX);
		x_hi = fit_size(32'(dst_w_cfg), DST_MAX) + 1;
		y_hi = fit_size(32'(dst_h_cfg), DST_MAX) + 1;
		if (x_hi > 1023)
			x_hi = 1023;
		if (y_hi > 1023)
			y_hi = 1023;
		repeat (n) begin
			case ($urandom_range(0, 19))
				0: begin
					// beyond the store, dropped by the block
					if ($urandom_range(0, 1))
						queue_store(10'($urandom_range(SRC_W_MAX, 1023)),
							10'($urandom_range(0, 1023)),
							8'($urandom), 8'($urandom), 8'($urandom));
					else
						queue_store(10'($urandom_range(0, 1023)),
							10'($urandom_range(SRC_H_MAX, 1023)),
							8'($urandom), 8'($urandom), 8'($urandom));
				end
				1, 2, 3, 4: queue_store(10'($urandom_range(0, sw - 1)),
					10'($urandom_range(0, sh - 1)),
					8'($urandom), 8'($urandom), 8'($urandom));
				5: queue_read(10'($urandom_range(0, 1023)), 10'($urandom_range(0, 1023)));
				default: queue_read(10'($urandom_range(0, x_hi)), 10'($urandom_range(0, y_hi)));
			endcase
		end
	endtask

	task automatic wait_drained();
		int unsigned waited;
		waited = 0;
		while ((stim_queue.size() != 0 || in_valid || levels_due.size() != 0) &&
				waited < DRAIN_LIMIT) begin
			@(posedge clk);
			waited++;
		end
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	always @(posedge clk) begin
		out_item_t want;
		if (arst_n) begin
			if (cfg_we) begin
				case (cfg_index)
					REG_SRC_W: src_w_cfg = cfg_wdata[9:0];
					REG_SRC_H: src_h_cfg = cfg_wdata[9:0];
					REG_DST_W: dst_w_cfg = cfg_wdata;
					REG_DST_H: dst_h_cfg = cfg_wdata;
					default: ;
				endcase
			end
			if (in_valid && in_ready) begin
				if (in_item.opcode == OP_STORE) begin
					if (in_item.x_coord < SRC_W_MAX && in_item.y_coord < SRC_H_MAX)
						src_pixels[in_item.y_coord * SRC_W_MAX + in_item.x_coord] =
							{in_item.red_in, in_item.green_in, in_item.blue_in};
				end else
					levels_due.push_back(resize_levels(in_item.x_coord, in_item.y_coord));
				in_taken = 1'b1;
			end
			if (out_valid && out_ready) begin
				if (levels_due.size() == 0)
					report_mismatch("result transaction with nothing outstanding");
				else begin
					want = levels_due.pop_front();
					if (out_item.red_level !== want.red_level)
						report_mismatch($sformatf("red_level %h, predicted %h",
							out_item.red_level, want.red_level));
					if (out_item.green_level !== want.green_level)
						report_mismatch($sformatf("green_level %h, predicted %h",
							out_item.green_level, want.green_level));
					if (out_item.blue_level !== want.blue_level)
						report_mismatch($sformatf("blue_level %h, predicted %h",
							out_item.blue_level, want.blue_level));
					if (out_item.is_padding !== want.is_padding)
						report_mismatch($sformatf("is_padding %b, predicted %b",
							out_item.is_padding, want.is_padding));
				end
			end
		end
	end

	// request driver
	always @(negedge clk) begin
		if (in_taken || !in_valid) begin
			in_taken = 1'b0;
			if (in_gap != 0) begin
				in_gap--;
				in_valid <= 1'b0;
			end else if (stim_queue.size() != 0) begin
				in_item  <= stim_queue.pop_front();
				in_valid <= 1'b1;
				if (bursts_on && $urandom_range(0, 5) == 0)
					in_gap = $urandom_range(1, 3);
			end else
				in_valid <= 1'b0;
		end
	end

	// result back-pressure
	always @(negedge clk) begin
		if (out_stall != 0) begin
			out_stall--;
			out_ready <= 1'b0;
		end else begin
			out_ready <= 1'b1;
			if (bursts_on && $urandom_range(0, 5) == 0)
				out_stall = $urandom_range(1, 3);
		end
	end

	initial begin
		logic [10:0] sw, sh, tw, th;
		repeat (RESET_CYCLES) @(negedge clk);
		arst_n <= 1'b1;

		// reset geometry: 512x512 into 640x640, no padding inside the frame
		queue_store(0, 0, 8'h00, 8'h00, 8'h00);
		queue_store(511, 511, 8'hff, 8'hff, 8'hff);
		queue_store(1, 0, 8'haa, 8'h55, 8'haa);
		queue_store(1023, 1023, 8'h55, 8'haa, 8'h55);
		queue_store(10'(SRC_W_MAX), 3, 8'h12, 8'h34, 8'h56);
		queue_store(3, 10'(SRC_H_MAX), 8'h12, 8'h34, 8'h56);
		queue_read(0, 0);
		queue_read(639, 639);
		queue_read(1, 0);
		queue_read(2, 0);
		queue_read(640, 5);
		queue_read(5, 640);
		queue_read(1023, 1023);
		queue_read(1023, 0);
		queue_read(0, 1023);
		// overwrite then read back
		queue_store(0, 0, 8'h12, 8'h34, 8'h56);
		queue_read(0, 0);
		queue_read(320, 320);

		for (int p = 0; p < NUM_PHASES; p++) begin
			// config writes only once the block is idle
			wait_drained();
			if (p < NUM_FIXED) begin
				sw = GEO_SET[p][0];
				sh = GEO_SET[p][1];
				tw = GEO_SET[p][2];
				th = GEO_SET[p][3];
			end else if ($urandom_range(0, 3) == 0) begin
				sw = 11'($urandom_range(0, 2047));
				sh = 11'($urandom_range(0, 2047));
				tw = 11'($urandom_range(0, 2047));
				th = 11'($urandom_range(0, 2047));
			end else begin
				sw = 11'($urandom_range(1, 24));
				sh = 11'($urandom_range(1, 24));
				tw = 11'($urandom_range(1, 64));
				th = 11'($urandom_range(1, 64));
			end
			if (p == NUM_PHASES - 1)
				bursts_on = 1'b0;
			@(negedge clk);
			cfg_we    <= 1'b1;
			cfg_index <= REG_SRC_W;
			cfg_wdata <= sw;
			@(negedge clk);
			cfg_index <= REG_SRC_H;
			cfg_wdata <= sh;
			@(negedge clk);
			cfg_index <= REG_DST_W;
			cfg_wdata <= tw;
			@(negedge clk);
			cfg_index <= REG_DST_H;
			cfg_wdata <= th;
			@(negedge clk);
			cfg_we <= 1'b0;
			queue_traffic(ITEMS_PER_PHASE);
		end

		wait_drained();
		if (levels_due.size() != 0)
			report_mismatch($sformatf("%0d read results never came back", levels_due.size()));
		if (mismatch_count == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

	initial begin
		#8000000;
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
